>>> hw/rtl/lprr_pkg.sv
// Shared request codes, status codes and header constants of the record ring.
`timescale 1ns / 1ps
package lprr_pkg;
   localparam int HEADER_BYTES = 4;
   localparam int MIN_RING_LEN = 16;

   localparam logic [1:0] REQ_WRITE_BEGIN = 2'd0;
   localparam logic [1:0] REQ_WRITE_BYTE  = 2'd1;
   localparam logic [1:0] REQ_READ        = 2'd2;
   localparam logic [1:0] REQ_RESET       = 2'd3;

   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_EMPTY     = 3'd1;
   localparam logic [2:0] ST_FULL      = 3'd2;
   localparam logic [2:0] ST_ERROR     = 3'd3;
   localparam logic [2:0] ST_NO_ENOUGH = 3'd4;
endpackage

>>> hw/rtl/length_prefixed_record_ring_unit.sv
// Top level of the length-prefixed record ring: request sequencer and ring memory.
`timescale 1ns / 1ps
// A request is taken when start is high and busy is low; each result appears
// on the rsp_ ports for one cycle with rsp_strobe and cannot be held off.
// Everything goes through one single-port byte memory, one access a cycle,
// which sets the timing: a write_byte can follow every cycle, write_begin
// keeps busy while the header is written (a full answer does not), a read
// keeps busy through header fetch, check, one payload byte per cycle and
// drain, and its bytes come out on consecutive cycles. A ring reset does
// not keep busy. No clearing pass is needed.
module length_prefixed_record_ring_unit
   import lprr_pkg::*;
#(
   parameter int RING_BYTES = 4096,
   parameter int MAX_MSG    = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_type,
   input  logic [6:0]  req_msg_len,
   input  logic [7:0]  req_data_byte,
   input  logic [6:0]  req_read_capacity,
   output logic        rsp_strobe,
   output logic [2:0]  rsp_status,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_byte_valid,
   output logic        rsp_last,
   output logic [6:0]  rsp_read_len,
   input  logic        csr_write_enable,
   input  logic [12:0] csr_write_data
);
   localparam int PW = $clog2(RING_BYTES + 1);
   localparam int AW = $clog2(RING_BYTES);
   localparam int XW = PW + 2;
   localparam int CW = (PW > 13) ? PW : 13;
   localparam int BLEN_RST = (4096 > RING_BYTES) ? RING_BYTES : 4096;

   typedef enum logic [2:0] {
      S_IDLE, S_HDR_WR, S_RD_HDR, S_RD_CHK, S_RD_DATA, S_RD_LAST
   } state_type;

   typedef enum logic [1:0] {
      M_MID, M_END, M_WRAP
   } mode_type;

   state_type     state_ff;
   mode_type      mode_ff;
   logic [PW-1:0] blen_ff, head_ff, tail_ff, wptr_ff, hpos_ff;
   logic [6:0]    wrem_ff, cnt_ff, cap_ff, hlen_ff;
   logic          wacc_ff, pend_ff, plast_ff;
   logic [1:0]    k_ff;
   logic [7:0]    hb0_ff, hb1_ff, hb2_ff;
   logic [7:0]    rdata_ff;

   logic          rsp_strobe_ff, rsp_byte_valid_ff, rsp_last_ff;
   logic [2:0]    rsp_status_ff;
   logic [7:0]    rsp_out_byte_ff;
   logic [6:0]    rsp_read_len_ff;

   logic          accept;
   logic          mem_we;
   logic [PW-1:0] mem_pos;
   logic [7:0]    mem_wd;
   logic          pl_ok;
   logic [PW-1:0] pl_hdr, pl_data, pl_tail;

   logic          chk_big, chk_err;
   logic [PW-1:0] chk_head;
   logic [XW-1:0] xh, xt, xb, xlen, xhb;
   logic [CW-1:0] csr_wide;
   logic [PW-1:0] csr_blen;

   assign busy   = (state_ff != S_IDLE);
   assign accept = start && !busy;

   lprr_place #(.PW(PW), .MAX_MSG(MAX_MSG)) u_place (
      .head(head_ff), .tail(tail_ff), .blen(blen_ff), .msg_len(req_msg_len),
      .ok(pl_ok), .hdr_at(pl_hdr), .data_at(pl_data), .new_tail(pl_tail)
   );

   always_comb begin
      mem_we  = 1'b0;
      mem_pos = head_ff;
      mem_wd  = req_data_byte;
      case (state_ff)
         S_IDLE: begin
            mem_pos = wptr_ff;
            mem_we  = accept && (req_type == REQ_WRITE_BYTE) && wacc_ff && (wrem_ff != '0);
         end
         S_HDR_WR: begin
            mem_we  = 1'b1;
            mem_pos = hpos_ff + PW'(k_ff);
            mem_wd  = (k_ff == 2'd0) ? {1'b0, hlen_ff} : 8'd0;
         end
         S_RD_HDR: mem_pos = hpos_ff + PW'(k_ff);
         default:  mem_pos = head_ff;
      endcase
   end

   lprr_mem #(.DEPTH(RING_BYTES), .AW(AW)) u_mem (
      .clock(clock), .we(mem_we), .addr(mem_pos[AW-1:0]), .wdata(mem_wd),
      .rdata_ff(rdata_ff)
   );

   // Header check once the last header byte is on the memory output.
   always_comb begin
      xh   = {2'b00, hpos_ff};
      xt   = {2'b00, tail_ff};
      xb   = {2'b00, blen_ff};
      xlen = {{(XW-8){1'b0}}, hb0_ff};
      xhb  = XW'(HEADER_BYTES);
      chk_big  = ((hb1_ff | hb2_ff | rdata_ff) != 8'd0) || (hb0_ff > 8'(MAX_MSG));
      chk_err  = chk_big;
      chk_head = PW'(xh + xhb);
      case (mode_ff)
         M_MID: chk_err = chk_big || (xh + xhb + xlen > xt);
         M_END: begin
            if (!chk_big && (xlen + xh + xhb > xb)) begin
               chk_head = '0;
               chk_err  = (tail_ff == '0) || (xt < xhb) || (xlen > xt);
            end
         end
         default: begin
            chk_err  = chk_big || (xhb + xlen > xt);
            chk_head = PW'(xhb);
         end
      endcase
   end

   always_comb begin
      csr_wide = CW'(csr_write_data);
      if (csr_wide < CW'(MIN_RING_LEN)) begin
         csr_blen = PW'(MIN_RING_LEN);
      end else if (csr_wide > CW'(RING_BYTES)) begin
         csr_blen = PW'(RING_BYTES);
      end else begin
         csr_blen = PW'(csr_wide);
      end
   end

   always_ff @(posedge clock) begin
      rsp_strobe_ff     <= 1'b0;
      rsp_status_ff     <= ST_OK;
      rsp_out_byte_ff   <= 8'd0;
      rsp_byte_valid_ff <= 1'b0;
      rsp_last_ff       <= 1'b1;
      rsp_read_len_ff   <= 7'd0;
      pend_ff           <= 1'b0;
      if (pend_ff) begin
         rsp_strobe_ff     <= 1'b1;
         rsp_out_byte_ff   <= rdata_ff;
         rsp_byte_valid_ff <= 1'b1;
         rsp_last_ff       <= plast_ff;
         rsp_read_len_ff   <= hlen_ff;
      end
      if (reset) begin
         state_ff      <= S_IDLE;
         blen_ff       <= PW'(BLEN_RST);
         head_ff       <= '0;
         tail_ff       <= '0;
         wptr_ff       <= '0;
         wrem_ff       <= '0;
         wacc_ff       <= 1'b0;
         pend_ff       <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else if (csr_write_enable) begin
         blen_ff <= csr_blen;
         head_ff <= '0;
         tail_ff <= '0;
         wptr_ff <= '0;
         wrem_ff <= '0;
         wacc_ff <= 1'b0;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  cap_ff <= req_read_capacity;
                  k_ff   <= 2'd0;
                  case (req_type)
                     REQ_WRITE_BEGIN: begin
                        wacc_ff <= pl_ok;
                        wrem_ff <= pl_ok ? req_msg_len : 7'd0;
                        if (pl_ok) begin
                           hpos_ff  <= pl_hdr;
                           hlen_ff  <= req_msg_len;
                           tail_ff  <= pl_tail;
                           wptr_ff  <= pl_data;
                           state_ff <= S_HDR_WR;
                        end else begin
                           rsp_strobe_ff <= 1'b1;
                           rsp_status_ff <= ST_FULL;
                        end
                     end
                     REQ_WRITE_BYTE: begin
                        if (mem_we) begin
                           wptr_ff <= wptr_ff + PW'(1);
                           wrem_ff <= wrem_ff - 7'd1;
                        end
                     end
                     REQ_RESET: begin
                        head_ff       <= '0;
                        tail_ff       <= '0;
                        wptr_ff       <= '0;
                        wrem_ff       <= '0;
                        wacc_ff       <= 1'b0;
                        rsp_strobe_ff <= 1'b1;
                     end
                     default: begin
                        if (head_ff == tail_ff) begin
                           rsp_strobe_ff <= 1'b1;
                           rsp_status_ff <= ST_EMPTY;
                        end else if (head_ff < tail_ff) begin
                           if ({2'b00, head_ff} + XW'(HEADER_BYTES) > {2'b00, tail_ff}) begin
                              head_ff       <= '0;
                              tail_ff       <= '0;
                              wptr_ff       <= '0;
                              wrem_ff       <= '0;
                              wacc_ff       <= 1'b0;
                              rsp_strobe_ff <= 1'b1;
                              rsp_status_ff <= ST_ERROR;
                           end else begin
                              hpos_ff  <= head_ff;
                              mode_ff  <= M_MID;
                              state_ff <= S_RD_HDR;
                           end
                        end else if ({2'b00, head_ff} + XW'(HEADER_BYTES)
                                     <= {2'b00, blen_ff}) begin
                           hpos_ff  <= head_ff;
                           mode_ff  <= M_END;
                           state_ff <= S_RD_HDR;
                        end else begin
                           // Too close to the end for a header: it sits at the start.
                           head_ff <= '0;
                           if (tail_ff == '0) begin
                              rsp_strobe_ff <= 1'b1;
                              rsp_status_ff <= ST_EMPTY;
                           end else if (tail_ff < PW'(HEADER_BYTES)) begin
                              tail_ff       <= '0;
                              wptr_ff       <= '0;
                              wrem_ff       <= '0;
                              wacc_ff       <= 1'b0;
                              rsp_strobe_ff <= 1'b1;
                              rsp_status_ff <= ST_ERROR;
                           end else begin
                              hpos_ff  <= '0;
                              mode_ff  <= M_WRAP;
                              state_ff <= S_RD_HDR;
                           end
                        end
                     end
                  endcase
               end
            end
            S_HDR_WR: begin
               k_ff <= k_ff + 2'd1;
               if (k_ff == 2'd3) begin
                  rsp_strobe_ff <= 1'b1;
                  state_ff      <= S_IDLE;
               end
            end
            S_RD_HDR: begin
               k_ff <= k_ff + 2'd1;
               case (k_ff)
                  2'd1:    hb0_ff <= rdata_ff;
                  2'd2:    hb1_ff <= rdata_ff;
                  2'd3:    hb2_ff <= rdata_ff;
                  default: hb0_ff <= hb0_ff;
               endcase
               if (k_ff == 2'd3) begin
                  state_ff <= S_RD_CHK;
               end
            end
            S_RD_CHK: begin
               hlen_ff       <= hb0_ff[6:0];
               cnt_ff        <= hb0_ff[6:0];
               rsp_strobe_ff <= 1'b1;
               state_ff      <= S_IDLE;
               if (chk_err) begin
                  head_ff       <= '0;
                  tail_ff       <= '0;
                  wptr_ff       <= '0;
                  wrem_ff       <= '0;
                  wacc_ff       <= 1'b0;
                  rsp_status_ff <= ST_ERROR;
               end else if (hb0_ff[6:0] > cap_ff) begin
                  head_ff         <= chk_head + PW'(hb0_ff[6:0]);
                  rsp_status_ff   <= ST_NO_ENOUGH;
                  rsp_read_len_ff <= hb0_ff[6:0];
               end else if (hb0_ff[6:0] == 7'd0) begin
                  head_ff <= chk_head;
               end else begin
                  head_ff       <= chk_head;
                  rsp_strobe_ff <= 1'b0;
                  state_ff      <= S_RD_DATA;
               end
            end
            S_RD_DATA: begin
               head_ff  <= head_ff + PW'(1);
               cnt_ff   <= cnt_ff - 7'd1;
               pend_ff  <= 1'b1;
               plast_ff <= (cnt_ff == 7'd1);
               if (cnt_ff == 7'd1) begin
                  state_ff <= S_RD_LAST;
               end
            end
            S_RD_LAST: state_ff <= S_IDLE;
            default:   state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_strobe     = rsp_strobe_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_out_byte   = rsp_out_byte_ff;
   assign rsp_byte_valid = rsp_byte_valid_ff;
   assign rsp_last       = rsp_last_ff;
   assign rsp_read_len   = rsp_read_len_ff;
endmodule

>>> hw/rtl/lprr_mem.sv
// Single-port byte memory with a registered read.
`timescale 1ns / 1ps
module lprr_mem #(
   parameter int DEPTH = 4096,
   parameter int AW    = 12
) (
   input  logic          clock,
   input  logic          we,
   input  logic [AW-1:0] addr,
   input  logic [7:0]    wdata,
   output logic [7:0]    rdata_ff
);
   logic [7:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end
endmodule

>>> hw/rtl/lprr_place.sv
// Room check and placement of a new record for a write_begin transaction.
`timescale 1ns / 1ps
module lprr_place
   import lprr_pkg::*;
#(
   parameter int PW      = 13,
   parameter int MAX_MSG = 64
) (
   input  logic [PW-1:0] head,
   input  logic [PW-1:0] tail,
   input  logic [PW-1:0] blen,
   input  logic [6:0]    msg_len,
   output logic          ok,
   output logic [PW-1:0] hdr_at,
   output logic [PW-1:0] data_at,
   output logic [PW-1:0] new_tail
);
   localparam int XW = PW + 2;

   logic [XW-1:0] h, t, b, l, hb;

   always_comb begin
      h  = {2'b00, head};
      t  = {2'b00, tail};
      b  = {2'b00, blen};
      l  = {{(XW-7){1'b0}}, msg_len};
      hb = XW'(HEADER_BYTES);
      ok       = 1'b0;
      hdr_at   = tail;
      data_at  = PW'(t + hb);
      new_tail = PW'(t + hb + l);
      if (msg_len <= 7'(MAX_MSG)) begin
         if (h <= t) begin
            if (t + hb + l <= b) begin
               ok = 1'b1;
            end else if (t + hb <= b) begin
               // Header fits at the end, payload wraps to the start.
               ok       = (l < h);
               data_at  = '0;
               new_tail = PW'(l);
            end else begin
               ok       = (l + hb < h);
               hdr_at   = '0;
               data_at  = PW'(hb);
               new_tail = PW'(hb + l);
            end
         end else begin
            ok = (t + hb + l < h);
         end
      end
   end
endmodule

>>> dv/lprr_checker.sv
// Checker of the record ring: watches both channels, predicts every answer and compares it.
`timescale 1ns / 1ps
module lprr_checker
   import lprr_pkg::*;
#(
   parameter int RING_BYTES = 4096,
   parameter int MAX_MSG    = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  logic [1:0]  req_type,
   input  logic [6:0]  req_msg_len,
   input  logic [7:0]  req_data_byte,
   input  logic [6:0]  req_read_capacity,
   input  logic        rsp_strobe,
   input  logic [2:0]  rsp_status,
   input  logic [7:0]  rsp_out_byte,
   input  logic        rsp_byte_valid,
   input  logic        rsp_last,
   input  logic [6:0]  rsp_read_len,
   input  logic        csr_write_enable,
   input  logic [12:0] csr_write_data,
   output int          fail_count,
   output int          pending,
   output int          answers_seen
);
   typedef struct packed {
      logic [2:0] status;
      logic [7:0] out_byte;
      logic       byte_valid;
      logic       last;
      logic [6:0] read_len;
   } ring_answer_t;

   ring_answer_t answer_q[$];

   logic [7:0]  mirror_mem [RING_BYTES];
   logic [12:0] ring_len_reg;
   int unsigned head, tail, msg_len_found, fill_ptr, fill_left;
   bit          fill_open;

   initial begin
      for (int i = 0; i < RING_BYTES; i++) mirror_mem[i] = 8'h00;
      fail_count   = 0;
      pending      = 0;
      answers_seen = 0;
   end

   function automatic int unsigned active_len();
      int unsigned b;
      b = ring_len_reg;
      if (b < MIN_RING_LEN) b = MIN_RING_LEN;
      if (b > RING_BYTES) b = RING_BYTES;
      return b;
   endfunction

   function automatic logic [7:0] mem_get(int unsigned pos);
      return (pos < RING_BYTES) ? mirror_mem[pos] : 8'h00;
   endfunction

   function automatic void mem_put(int unsigned pos, logic [7:0] v);
      if (pos < RING_BYTES) mirror_mem[pos] = v;
   endfunction

   function automatic int unsigned header_at(int unsigned pos);
      int unsigned v;
      v = 0;
      for (int i = HEADER_BYTES - 1; i >= 0; i--) v = (v << 8) | mem_get(pos + i);
      return v;
   endfunction

   function automatic void clear_pointers();
      head      = 0;
      tail      = 0;
      msg_len_found = 0;
      fill_ptr  = 0;
      fill_left = 0;
      fill_open = 0;
   endfunction

   function automatic void push_answer(logic [2:0] st, logic [7:0] b, logic v, logic l,
                                       logic [6:0] rl);
      ring_answer_t a;
      a.status     = st;
      a.out_byte   = b;
      a.byte_valid = v;
      a.last       = l;
      a.read_len   = rl;
      answer_q.push_back(a);
   endfunction

   // Locates the next record; on ok head points at its payload.
   function automatic logic [2:0] locate_record();
      int unsigned b, h, t, len;
      b = active_len();
      h = head;
      t = tail;
      len = 0;
      if (h < t) begin
         if (h + HEADER_BYTES > t) return ST_ERROR;
         len = header_at(h);
         if (len > MAX_MSG || h + HEADER_BYTES + len > t) return ST_ERROR;
         head = h + HEADER_BYTES;
      end else if (h > t) begin
         if (h + HEADER_BYTES <= b) begin
            len = header_at(h);
            if (len > MAX_MSG) return ST_ERROR;
            if (len + h + HEADER_BYTES > b) begin
               head = 0;
               if (t == 0 || HEADER_BYTES > t || len > t) return ST_ERROR;
            end else begin
               head = h + HEADER_BYTES;
            end
         end else begin
            head = 0;
            if (t == 0) return ST_EMPTY;
            if (HEADER_BYTES > t) return ST_ERROR;
            len = header_at(0);
            if (len > MAX_MSG || HEADER_BYTES + len > t) return ST_ERROR;
            head = HEADER_BYTES;
         end
      end else begin
         return ST_EMPTY;
      end
      msg_len_found = len;
      return ST_OK;
   endfunction

   function automatic logic [2:0] reserve_record(int unsigned l);
      int unsigned b, h, t, hdr_pos, data_pos, new_tail;
      b = active_len();
      h = head;
      t = tail;
      fill_open = 0;
      fill_left = 0;
      if (l > MAX_MSG) return ST_FULL;
      if (h <= t) begin
         if (t + HEADER_BYTES + l <= b) begin
            hdr_pos = t; data_pos = t + HEADER_BYTES; new_tail = t + HEADER_BYTES + l;
         end else if (t + HEADER_BYTES <= b) begin
            if (!(l < h)) return ST_FULL;
            hdr_pos = t; data_pos = 0; new_tail = l;
         end else begin
            if (!(l + HEADER_BYTES < h)) return ST_FULL;
            hdr_pos = 0; data_pos = HEADER_BYTES; new_tail = HEADER_BYTES + l;
         end
      end else begin
         if (!(t + HEADER_BYTES + l < h)) return ST_FULL;
         hdr_pos = t; data_pos = t + HEADER_BYTES; new_tail = t + HEADER_BYTES + l;
      end
      for (int i = 0; i < HEADER_BYTES; i++) mem_put(hdr_pos + i, 8'((l >> (8 * i)) & 8'hFF));
      tail      = new_tail;
      fill_ptr  = data_pos;
      fill_left = l;
      fill_open = 1;
      return ST_OK;
   endfunction

   function automatic void predict_request();
      logic [2:0] st;
      case (req_type)
         REQ_WRITE_BEGIN: begin
            push_answer(reserve_record(req_msg_len), 8'h00, 1'b0, 1'b1, 7'd0);
         end
         REQ_WRITE_BYTE: begin
            if (fill_open && fill_left > 0) begin
               mem_put(fill_ptr, req_data_byte);
               fill_ptr  = (fill_ptr + 1) & 32'hFFFFF;
               fill_left = fill_left - 1;
            end
         end
         REQ_RESET: begin
            clear_pointers();
            push_answer(ST_OK, 8'h00, 1'b0, 1'b1, 7'd0);
         end
         default: begin
            st = locate_record();
            if (st == ST_ERROR) begin
               clear_pointers();
               push_answer(ST_ERROR, 8'h00, 1'b0, 1'b1, 7'd0);
            end else if (st == ST_EMPTY) begin
               push_answer(ST_EMPTY, 8'h00, 1'b0, 1'b1, 7'd0);
            end else if (msg_len_found > req_read_capacity) begin
               push_answer(ST_NO_ENOUGH, 8'h00, 1'b0, 1'b1, 7'(msg_len_found));
               head = head + msg_len_found;
            end else if (msg_len_found == 0) begin
               push_answer(ST_OK, 8'h00, 1'b0, 1'b1, 7'd0);
            end else begin
               for (int unsigned i = 0; i < msg_len_found; i++)
                  push_answer(ST_OK, mem_get(head + i), 1'b1, (i + 1 == msg_len_found),
                              7'(msg_len_found));
               head = head + msg_len_found;
            end
         end
      endcase
   endfunction

   always @(posedge clock) begin
      ring_answer_t exp_a;
      ring_answer_t got_a;
      if (reset) begin
         ring_len_reg = 13'd4096;
         clear_pointers();
         answer_q.delete();
      end else begin
         // Answers at this edge belong to older transactions, so compare first.
         if (rsp_strobe) begin
            answers_seen++;
            got_a = {rsp_status, rsp_out_byte, rsp_byte_valid, rsp_last, rsp_read_len};
            if (answer_q.size() == 0) begin
               fail_count++;
               $display("%0t: unexpected answer status=%0d byte=%0h valid=%0d last=%0d len=%0d",
                        $time, rsp_status, rsp_out_byte, rsp_byte_valid, rsp_last, rsp_read_len);
            end else begin
               exp_a = answer_q.pop_front();
               if (got_a !== exp_a) begin
                  fail_count++;
                  $display("%0t: mismatch expected status=%0d byte=%0h valid=%0d last=%0d len=%0d",
                           $time, exp_a.status, exp_a.out_byte, exp_a.byte_valid, exp_a.last,
                           exp_a.read_len);
                  $display("%0t:          actual   status=%0d byte=%0h valid=%0d last=%0d len=%0d",
                           $time, rsp_status, rsp_out_byte, rsp_byte_valid, rsp_last,
                           rsp_read_len);
               end
            end
         end
         if (csr_write_enable) begin
            ring_len_reg = csr_write_data;
            clear_pointers();
         end
         if (start && !busy) predict_request();
      end
      pending = answer_q.size();
   end
endmodule

>>> dv/tb_top.sv
// Testbench top of the record ring: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module tb_top;
   import lprr_pkg::*;

   localparam int IDLE_LIMIT = 20000;
   localparam int MAX_MSG    = 64;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [1:0]  req_type = REQ_RESET;
   logic [6:0]  req_msg_len = 7'd0;
   logic [7:0]  req_data_byte = 8'd0;
   logic [6:0]  req_read_capacity = 7'd0;
   logic        rsp_strobe;
   logic [2:0]  rsp_status;
   logic [7:0]  rsp_out_byte;
   logic        rsp_byte_valid;
   logic        rsp_last;
   logic [6:0]  rsp_read_len;
   logic        csr_write_enable = 1'b0;
   logic [12:0] csr_write_data = 13'd0;

   int fail_count, pending, answers_seen;
   int item_count = 0;
   int burst_left = 0;
   int idle_cycles = 0;
   int len_settings = 0;

   length_prefixed_record_ring_unit i_dut (
      .clock, .reset, .start, .busy, .req_type, .req_msg_len, .req_data_byte,
      .req_read_capacity, .rsp_strobe, .rsp_status, .rsp_out_byte, .rsp_byte_valid,
      .rsp_last, .rsp_read_len, .csr_write_enable, .csr_write_data
   );

   lprr_checker i_checker (
      .clock, .reset, .start, .busy, .req_type, .req_msg_len, .req_data_byte,
      .req_read_capacity, .rsp_strobe, .rsp_status, .rsp_out_byte, .rsp_byte_valid,
      .rsp_last, .rsp_read_len, .csr_write_enable, .csr_write_data,
      .fail_count, .pending, .answers_seen
   );

   initial begin
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe || csr_write_enable) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles == IDLE_LIMIT) begin
            $display("length_prefixed_record_ring_unit test failed");
            $finish;
         end
      end
   end

   // Presents one transaction and returns at the edge that accepts it.
   task automatic send(logic [1:0] t, logic [6:0] len, logic [7:0] b, logic [6:0] cap);
      start             <= 1'b1;
      req_type          <= t;
      req_msg_len       <= len;
      req_data_byte     <= b;
      req_read_capacity <= cap;
      forever begin
         @(negedge clock);
         if (!busy) break;
         @(posedge clock);
      end
      @(posedge clock);
      item_count++;
   endtask

   task automatic idle_gap(int n);
      start <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   // Sender works in bursts; a gap of random length follows each one.
   task automatic maybe_gap();
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         idle_gap($urandom_range(1, 8));
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(0, 10);
      end
   endtask

   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(negedge clock);
      @(posedge clock);
      // A trailing write_byte gives no answer; let the block settle.
      repeat (12) @(posedge clock);
   endtask

   task automatic set_ring_len(logic [12:0] v);
      drain();
      csr_write_enable <= 1'b1;
      csr_write_data   <= v;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      @(posedge clock);
      len_settings++;
   endtask

   task automatic write_record(int len, int nbytes);
      send(REQ_WRITE_BEGIN, 7'(len), 8'($urandom), 7'($urandom));
      for (int i = 0; i < nbytes; i++) begin
         maybe_gap();
         send(REQ_WRITE_BYTE, 7'($urandom), 8'($urandom), 7'($urandom));
      end
   endtask

   task automatic random_phase(int n);
      int stop_at, len, nbytes, pick;
      stop_at = item_count + n;
      while (item_count < stop_at) begin
         pick = $urandom_range(0, 99);
         if (pick < 55) begin
            pick = $urandom_range(0, 19);
            len = (pick < 14) ? $urandom_range(0, 12) :
                  (pick < 19) ? $urandom_range(13, 64) : $urandom_range(65, 127);
            // An accepted record always gets its whole payload, so no read ever
            // meets a byte that was never written.
            nbytes = (len > MAX_MSG) ? $urandom_range(0, 3) : len;
            if ($urandom_range(0, 9) == 0) nbytes = nbytes + $urandom_range(1, 3);
            write_record(len, nbytes);
         end else if (pick < 85) begin
            send(REQ_READ, 7'($urandom), 8'($urandom),
                 ($urandom_range(0, 3) == 0) ? 7'($urandom_range(0, 127)) : 7'd64);
         end else if (pick < 90) begin
            send(REQ_RESET, 7'($urandom), 8'($urandom), 7'($urandom));
         end else if (pick < 95) begin
            send(REQ_WRITE_BYTE, 7'($urandom), 8'($urandom), 7'($urandom));
         end else begin
            send(REQ_WRITE_BEGIN,
                 ($urandom_range(0, 3) == 0) ? 7'd0 : 7'($urandom_range(65, 127)),
                 8'($urandom), 7'($urandom));
         end
         maybe_gap();
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part.
      send(REQ_RESET, 7'd0, 8'd0, 7'd0);
      send(REQ_READ, 7'd0, 8'd0, 7'd64);
      write_record(0, 0);
      send(REQ_READ, 7'd0, 8'd0, 7'd0);
      write_record(64, 64);
      send(REQ_READ, 7'd0, 8'd0, 7'd63);
      write_record(3, 3);
      send(REQ_READ, 7'd127, 8'hFF, 7'd127);
      send(REQ_WRITE_BEGIN, 7'd65, 8'd0, 7'd0);
      send(REQ_WRITE_BEGIN, 7'd127, 8'd0, 7'd0);
      send(REQ_WRITE_BYTE, 7'd0, 8'hFF, 7'd0);
      // The short record below lands on the payload bytes of this one, so the
      // bytes it leaves out still hold known data.
      send(REQ_RESET, 7'd0, 8'd0, 7'd0);
      write_record(5, 5);
      send(REQ_READ, 7'd0, 8'd0, 7'd64);
      send(REQ_RESET, 7'd0, 8'd0, 7'd0);
      write_record(5, 2);
      write_record(2, 2);
      send(REQ_READ, 7'd0, 8'd0, 7'd64);
      send(REQ_READ, 7'd0, 8'd0, 7'd64);
      send(REQ_READ, 7'd0, 8'd0, 7'd64);
      drain();

      // Smallest ring: wraps and full answers come quickly.
      set_ring_len(13'd16);
      write_record(8, 8);
      write_record(4, 4);
      send(REQ_READ, 7'd0, 8'd0, 7'd64);
      write_record(6, 6);
      send(REQ_READ, 7'd0, 8'd0, 7'd64);
      send(REQ_READ, 7'd0, 8'd0, 7'd64);
      random_phase(10);

      set_ring_len(13'd0);
      random_phase(6);
      drain();
      set_ring_len(13'($urandom_range(17, 200)));
      random_phase(10);
      set_ring_len(13'd8191);
      random_phase(8);
      set_ring_len(13'd4096);
      random_phase(8);
      set_ring_len(13'($urandom_range(40, 120)));
      random_phase(8);

      drain();
      $display("Covered %0d transactions and %0d answers: record writes, reads, resets,",
               item_count, answers_seen);
      $display("full, empty, error and short-capacity cases over %0d ring length settings.",
               len_settings);
      if (fail_count == 0) begin
         $display("length_prefixed_record_ring_unit test passed");
      end else begin
         $display("length_prefixed_record_ring_unit test failed");
      end
      $finish;
   end
endmodule
